FILE: design/ring_sector_vertex_generator_macros.svh
// assertion macros for the ring sector vertex generator
// used by the top level; no other dependencies
`ifndef RING_SECTOR_VERTEX_GENERATOR_MACROS_SVH
`define RING_SECTOR_VERTEX_GENERATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RSVG_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RSVG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`define RSVG_ASSERT_RESET(label, clk, rstn, cons) \
    label: assert property (@(posedge clk) (!rstn) |=> (cons)) \
        else $error("assertion failed");
`else
`define RSVG_ASSERT_SAME(label, clk, rstn, ante, cons)
`define RSVG_ASSERT_NEXT(label, clk, rstn, ante, cons)
`define RSVG_ASSERT_RESET(label, clk, rstn, cons)
`endif
`endif

FILE: design/rsvg_pkg.sv
// shared constants, types and helpers for the ring sector vertex generator
// no dependencies
package rsvg_pkg;

    localparam int MAX_SEGMENTS  = 1023;
    localparam int CORDIC_STAGES = 16;
    localparam int COORD_BITS    = 16;

    localparam int SEG_W   = 10;
    localparam int ANG_W   = 17;
    localparam int PROD_W  = SEG_W + ANG_W;
    localparam int RAD_W   = 16;
    localparam int CW      = 33;
    localparam int MUL_W   = CW + RAD_W;
    localparam int SHIFT_W = 5;

    localparam logic [SEG_W-1:0] SEG_MAX   = SEG_W'(MAX_SEGMENTS);
    localparam logic [ANG_W-1:0] FULL_TURN = 17'h10000;
    localparam logic signed [CW-1:0] CORDIC_X0 = 33'sd652032874;

    // register indexes
    localparam logic [2:0] REG_SEGMENT_COUNT = 3'd0;
    localparam logic [2:0] REG_INNER_RADIUS  = 3'd1;
    localparam logic [2:0] REG_OUTER_RADIUS  = 3'd2;
    localparam logic [2:0] REG_OPEN_ANGLE    = 3'd3;
    localparam logic [2:0] REG_ANGLE_MODE    = 3'd4;

    // angle modes
    localparam logic [1:0] MODE_CW   = 2'd0;
    localparam logic [1:0] MODE_CCW  = 2'd1;
    localparam logic [1:0] MODE_SYM  = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    // atan(2^-k) as 32-bit turn fractions
    localparam logic [31:0] ATAN_TURN32 [0:23] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    typedef struct packed {
        logic             vld;
        logic [SEG_W-1:0] rem;
        logic [ANG_W-1:0] dbits;
        logic [ANG_W-1:0] quo;
    } div_t;

    typedef struct packed {
        logic                 vld;
        logic                 flip;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cord_t;

    // round half up by 2^30 and saturate to the coordinate range
    function automatic logic [15:0] round_sat(input logic signed [MUL_W-1:0] p);
        logic signed [MUL_W-1:0] r;
        logic signed [MUL_W-1:0] hi;
        logic signed [MUL_W-1:0] lo;
        r  = (p + (MUL_W'(1) <<< 29)) >>> 30;
        hi = (MUL_W'(1) <<< (COORD_BITS - 1)) - MUL_W'(1);
        lo = -hi - MUL_W'(1);
        if (r > hi) begin
            r = hi;
        end else if (r < lo) begin
            r = lo;
        end
        return r[15:0];
    endfunction

endpackage

FILE: design/rsvg_div_cell.sv
// one restoring division step: one quotient bit per cell
// depends on rsvg_pkg
module rsvg_div_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic [rsvg_pkg::SEG_W-1:0]  divisor,
    input  rsvg_pkg::div_t              d_in,
    output rsvg_pkg::div_t              d_out
);

    rsvg_pkg::div_t              d_reg;
    rsvg_pkg::div_t              d_next;
    logic [rsvg_pkg::SEG_W:0]    trial;
    logic                        ge;

    // shift in the next dividend bit and try a subtract
    always_comb begin
        trial  = {d_in.rem, d_in.dbits[rsvg_pkg::ANG_W-1]};
        ge     = trial >= {1'b0, divisor};
        d_next = d_in;
        d_next.rem   = ge ? rsvg_pkg::SEG_W'(trial - {1'b0, divisor})
                          : trial[rsvg_pkg::SEG_W-1:0];
        d_next.dbits = {d_in.dbits[rsvg_pkg::ANG_W-2:0], 1'b0};
        d_next.quo   = {d_in.quo[rsvg_pkg::ANG_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg.vld <= 1'b0;
        end else if (adv) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

FILE: design/rsvg_cordic_cell.sv
// one rotation-mode cordic micro-rotation
// depends on rsvg_pkg
module rsvg_cordic_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic [rsvg_pkg::SHIFT_W-1:0]  shift,
    input  logic [31:0]                   atan,
    input  rsvg_pkg::cord_t               c_in,
    output rsvg_pkg::cord_t               c_out
);

    rsvg_pkg::cord_t                  c_reg;
    rsvg_pkg::cord_t                  c_next;
    logic signed [rsvg_pkg::CW-1:0]   xs;
    logic signed [rsvg_pkg::CW-1:0]   ys;
    logic signed [rsvg_pkg::CW-1:0]   at;

    // rotate toward zero residual angle
    always_comb begin
        xs = c_in.x >>> shift;
        ys = c_in.y >>> shift;
        at = $signed({1'b0, atan});
        c_next = c_in;
        if (!c_in.z[rsvg_pkg::CW-1]) begin
            c_next.x = c_in.x - ys;
            c_next.y = c_in.y + xs;
            c_next.z = c_in.z - at;
        end else begin
            c_next.x = c_in.x + ys;
            c_next.y = c_in.y - xs;
            c_next.z = c_in.z + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_reg.vld <= 1'b0;
        end else if (adv) begin
            c_reg <= c_next;
        end
    end

    assign c_out = c_reg;

endmodule

FILE: design/ring_sector_vertex_generator.sv
// top level: config registers, divider and cordic cell chains, output stage
// depends on rsvg_pkg, rsvg_div_cell, rsvg_cordic_cell and the macros header
//
//  channel   | direction | beat
//  s_        | in        | vertex_index
//  m_        | out       | pos_x, pos_y, on_outer, last (two beats per index)
//  cfg_      | in        | write enable, index, data
//
// from input beat to first output beat the data passes the input register,
// 17 divider cells, angle register, 16 cordic cells, multiply register, output.
// the two output beats of one index leave the single output port in turn; the
// whole chain stalls while the output holds an index, until its outer beat is
// taken, so no new index enters meanwhile. reset empties the chain.
// angle mode 3 accepts the beat and yields nothing.
`include "ring_sector_vertex_generator_macros.svh"
module ring_sector_vertex_generator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [2:0]                    cfg_addr,
    input  logic [rsvg_pkg::ANG_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rsvg_pkg::SEG_W-1:0]    s_vertex_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [15:0]            m_pos_x,
    output logic signed [15:0]            m_pos_y,
    output logic                          m_on_outer,
    output logic                          m_last
);

    localparam int NS = rsvg_pkg::CORDIC_STAGES;
    localparam int ND = rsvg_pkg::ANG_W;

    logic [rsvg_pkg::SEG_W-1:0]   seg_reg;
    logic signed [15:0]           rin_reg;
    logic signed [15:0]           rout_reg;
    logic [rsvg_pkg::ANG_W-1:0]   oa_reg;
    logic [1:0]                   mode_reg;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg  <= rsvg_pkg::SEG_W'(10);
            rin_reg  <= '0;
            rout_reg <= 16'sd4096;
            oa_reg   <= rsvg_pkg::FULL_TURN;
            mode_reg <= rsvg_pkg::MODE_CW;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                rsvg_pkg::REG_SEGMENT_COUNT: seg_reg  <= cfg_wdata[rsvg_pkg::SEG_W-1:0];
                rsvg_pkg::REG_INNER_RADIUS:  rin_reg  <= cfg_wdata[15:0];
                rsvg_pkg::REG_OUTER_RADIUS:  rout_reg <= cfg_wdata[15:0];
                rsvg_pkg::REG_OPEN_ANGLE:    oa_reg   <= cfg_wdata;
                rsvg_pkg::REG_ANGLE_MODE:    mode_reg <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // effective segment count, open angle and offset
    logic [rsvg_pkg::SEG_W-1:0]   n_eff;
    logic [rsvg_pkg::ANG_W-1:0]   oa_eff;
    logic [15:0]                  offset;

    always_comb begin
        n_eff  = (seg_reg == '0) ? rsvg_pkg::SEG_W'(1) : seg_reg;
        if (n_eff > rsvg_pkg::SEG_MAX) begin
            n_eff = rsvg_pkg::SEG_MAX;
        end
        oa_eff = (oa_reg > rsvg_pkg::FULL_TURN) ? rsvg_pkg::FULL_TURN : oa_reg;
        unique case (mode_reg)
            rsvg_pkg::MODE_CCW: offset = oa_eff[15:0];
            rsvg_pkg::MODE_SYM: offset = oa_eff[16:1];
            default:            offset = '0;
        endcase
    end

    // output stage state
    logic         hold_vld_reg;
    logic         phase_reg;
    logic [15:0]  xi_reg, yi_reg, xo_reg, yo_reg;
    logic         adv;

    assign adv     = !hold_vld_reg || (m_ready && phase_reg);
    assign s_ready = adv;

    // input register: saturate index and form index * open angle
    rsvg_pkg::div_t             in_reg;
    logic [rsvg_pkg::SEG_W-1:0] idx_sat;
    logic [rsvg_pkg::PROD_W-1:0] prod;

    always_comb begin
        idx_sat = (s_vertex_index > n_eff) ? n_eff : s_vertex_index;
        prod    = rsvg_pkg::PROD_W'(idx_sat) * rsvg_pkg::PROD_W'(oa_eff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_reg.vld <= 1'b0;
        end else if (adv) begin
            in_reg.vld   <= s_valid && (mode_reg != rsvg_pkg::MODE_NONE);
            in_reg.rem   <= prod[rsvg_pkg::PROD_W-1:ND];
            in_reg.dbits <= prod[ND-1:0];
            in_reg.quo   <= '0;
        end
    end

    // divider chain
    rsvg_pkg::div_t div_link [0:ND];
    assign div_link[0] = in_reg;

    for (genvar g = 0; g < ND; g++) begin : g_div
        rsvg_div_cell u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .divisor (n_eff),
            .d_in    (div_link[g]),
            .d_out   (div_link[g+1])
        );
    end

    // angle register: subtract offset, fold into the right half plane
    rsvg_pkg::cord_t  ang_reg;
    logic [15:0]      ang;
    logic [15:0]      quad;
    logic             flip;
    logic [15:0]      a16;

    always_comb begin
        ang  = div_link[ND].quo[15:0] - offset;
        quad = ang + 16'h4000;
        flip = quad[15];
        a16  = flip ? (ang + 16'h8000) : ang;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ang_reg.vld <= 1'b0;
        end else if (adv) begin
            ang_reg.vld  <= div_link[ND].vld;
            ang_reg.flip <= flip;
            ang_reg.x    <= rsvg_pkg::CORDIC_X0;
            ang_reg.y    <= '0;
            ang_reg.z    <= $signed({a16[15], a16, 16'h0000});
        end
    end

    // cordic chain
    rsvg_pkg::cord_t cord_link [0:NS];
    assign cord_link[0] = ang_reg;

    for (genvar k = 0; k < NS; k++) begin : g_cordic
        rsvg_cordic_cell u_cordic (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .shift   (rsvg_pkg::SHIFT_W'(k)),
            .atan    (rsvg_pkg::ATAN_TURN32[k]),
            .c_in    (cord_link[k]),
            .c_out   (cord_link[k+1])
        );
    end

    // multiply register: scale the unit vector by both radii
    logic signed [rsvg_pkg::CW-1:0]     cx, cy;
    logic                               mul_vld_reg;
    logic signed [rsvg_pkg::MUL_W-1:0]  pxi_reg, pyi_reg, pxo_reg, pyo_reg;

    always_comb begin
        cx = cord_link[NS].flip ? -cord_link[NS].x : cord_link[NS].x;
        cy = cord_link[NS].flip ? -cord_link[NS].y : cord_link[NS].y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg <= 1'b0;
        end else if (adv) begin
            mul_vld_reg <= cord_link[NS].vld;
            pxi_reg <= rsvg_pkg::MUL_W'(cx) * rsvg_pkg::MUL_W'(rin_reg);
            pyi_reg <= rsvg_pkg::MUL_W'(cy) * rsvg_pkg::MUL_W'(rin_reg);
            pxo_reg <= rsvg_pkg::MUL_W'(cx) * rsvg_pkg::MUL_W'(rout_reg);
            pyo_reg <= rsvg_pkg::MUL_W'(cy) * rsvg_pkg::MUL_W'(rout_reg);
        end
    end

    // output stage: round, saturate, then hand out inner and outer beats
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg <= 1'b0;
            phase_reg    <= 1'b0;
        end else if (adv) begin
            hold_vld_reg <= mul_vld_reg;
            phase_reg    <= 1'b0;
        end else if (m_ready) begin
            phase_reg    <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            xi_reg <= rsvg_pkg::round_sat(pxi_reg);
            yi_reg <= rsvg_pkg::round_sat(pyi_reg);
            xo_reg <= rsvg_pkg::round_sat(pxo_reg);
            yo_reg <= rsvg_pkg::round_sat(pyo_reg);
        end
    end

    assign m_valid    = hold_vld_reg;
    assign m_pos_x    = phase_reg ? xo_reg : xi_reg;
    assign m_pos_y    = phase_reg ? yo_reg : yi_reg;
    assign m_on_outer = phase_reg;
    assign m_last     = phase_reg;

    // checks
    `RSVG_ASSERT_NEXT(a_inner_then_outer, aclk, aresetn, m_valid && m_ready && !m_on_outer, m_valid && m_on_outer)
    `RSVG_ASSERT_NEXT(a_outer_holds, aclk, aresetn, m_valid && m_on_outer && !m_ready, m_valid && m_on_outer)
    `RSVG_ASSERT_SAME(a_last_frees_chain, aclk, aresetn, m_valid && m_last && m_ready, s_ready)
    `RSVG_ASSERT_RESET(a_reset_empty, aclk, aresetn, !m_valid)

endmodule
